/* rtl/dbr_pkg.sv */
// Shared types, constants and word helpers for the dynamic bitmap rank engine.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package dbr_pkg;

    localparam int MAX_BITS  = 1024;
    localparam int WORD_BITS = 32;
    localparam int NWORDS    = MAX_BITS / WORD_BITS;
    localparam int AW        = $clog2(NWORDS);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int LW        = $clog2(MAX_BITS) + 1;
    localparam int CW        = $clog2(WORD_BITS) + 1;

    localparam logic [3:0] OP_INIT   = 4'd0;
    localparam logic [3:0] OP_SET    = 4'd1;
    localparam logic [3:0] OP_CLEAR  = 4'd2;
    localparam logic [3:0] OP_TEST   = 4'd3;
    localparam logic [3:0] OP_FIND   = 4'd4;
    localparam logic [3:0] OP_RANK   = 4'd5;
    localparam logic [3:0] OP_INSERT = 4'd6;
    localparam logic [3:0] OP_DELETE = 4'd7;
    localparam logic [3:0] OP_SETALL = 4'd8;
    localparam logic [3:0] OP_COUNT  = 4'd9;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_SWEEP
    } t_state;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_word         wdata;
        logic [AW-1:0] raddr;
    } t_mem_req;

    function automatic t_word low_mask(input logic [BW-1:0] b);
        low_mask = (t_word'(1) << b) - t_word'(1);
    endfunction

    function automatic logic [CW-1:0] pop_count(input t_word w);
        logic [CW-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + CW'(w[i]);
        end
        pop_count = n;
    endfunction

    // index of the lowest set bit; zero when the word is empty
    function automatic logic [BW-1:0] first_one(input t_word w);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BW'(i);
            end
        end
        first_one = idx;
    endfunction

endpackage

`default_nettype wire

/* rtl/dynamic_bitmap_rank_engine.sv */
// Top level of the dynamic bitmap rank engine: sequencer plus word store.
// Depends on dbr_pkg, dbr_ctrl and dbr_mem.
//
//  channel   ports                                   transfer
//  request   start, busy, i_op, i_position,          start high, busy low
//            i_insert_value
//  result    o_valid, o_bit_value .. o_error         o_valid high, one cycle
//
// Cycles: count and refused requests strobe the cycle after the transfer.
// Set, clear and test handle one word; find, rank, insert and delete stay busy
// while they sweep the words one at a time through the single read port.
// Init and set all write every word with busy high.
// After reset the store is cleared in one pass over every word with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module dynamic_bitmap_rank_engine
    import dbr_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [3:0]    i_op,
    input  wire logic [LW-1:0] i_position,
    input  wire logic          i_insert_value,
    output logic               o_valid,
    output logic               o_bit_value,
    output logic               o_found,
    output logic [LW-2:0]      o_found_index,
    output logic [LW-1:0]      o_ones_count,
    output logic [LW-1:0]      o_current_length,
    output logic               o_any_zero,
    output logic               o_all_clear,
    output logic               o_error
);

    t_mem_req w_req;
    t_word    w_rdata;

    dbr_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_position       (i_position),
        .i_insert_value   (i_insert_value),
        .o_req            (w_req),
        .i_rdata          (w_rdata),
        .o_valid          (o_valid),
        .o_bit_value      (o_bit_value),
        .o_found          (o_found),
        .o_found_index    (o_found_index),
        .o_ones_count     (o_ones_count),
        .o_current_length (o_current_length),
        .o_any_zero       (o_any_zero),
        .o_all_clear      (o_all_clear),
        .o_error          (o_error)
    );

    dbr_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

endmodule

`default_nettype wire

/* rtl/dbr_mem.sv */
// Word store of the bitmap: one write port, one read port, registered read data.
// Depends on dbr_pkg for the word type and the request struct.
`default_nettype none

module dbr_mem
    import dbr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_word         o_rdata
);

    t_word r_mem [NWORDS];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/dbr_ctrl.sv */
// Sequencer and word datapath: decodes a request, sweeps the store word by word
// with read-modify-write, keeps length and ones count. Depends on dbr_pkg.
`default_nettype none

module dbr_ctrl
    import dbr_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [3:0]    i_op,
    input  wire logic [LW-1:0] i_position,
    input  wire logic          i_insert_value,
    output t_mem_req           o_req,
    input  wire t_word         i_rdata,
    output logic               o_valid,
    output logic               o_bit_value,
    output logic               o_found,
    output logic [LW-2:0]      o_found_index,
    output logic [LW-1:0]      o_ones_count,
    output logic [LW-1:0]      o_current_length,
    output logic               o_any_zero,
    output logic               o_all_clear,
    output logic               o_error
);

    t_state        r_state, n_state;
    logic [3:0]    r_op, n_op;
    logic [LW-1:0] r_pos, n_pos;
    logic          r_ival, n_ival;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_ones, n_ones;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_last, n_last;
    logic          r_down, n_down;
    logic          r_more, n_more;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_daddr, n_daddr;
    logic          r_carry, n_carry;
    logic [LW-1:0] r_acc, n_acc;
    logic          r_fillset, n_fillset;
    logic          r_report, n_report;

    logic          r_valid, r_bit, r_found, r_any_zero, r_all_clear, r_err;
    logic [LW-2:0] r_fidx;
    logic [LW-1:0] r_cnt, r_cur_len;

    logic          w_accept, w_done, w_go_fill, w_go_sweep;
    logic          w_bit, w_found, w_err;
    logic [LW-2:0] w_fidx;
    logic [LW-1:0] w_cnt;
    logic [LW-1:0] w_in_pm1, w_len_m1;
    logic [AW-1:0] w_in_wp;
    logic [BW-1:0] w_b;
    logic [AW-1:0] w_wp;
    t_word         w_low, w_masked, w_fill, w_shift;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_in_wp  = i_position[BW+AW-1:BW];
    assign w_in_pm1 = i_position - LW'(1);
    assign w_len_m1 = r_len - LW'(1);
    assign w_b      = r_pos[BW-1:0];
    assign w_wp     = r_pos[BW+AW-1:BW];
    assign w_low    = low_mask(w_b);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_go_fill) begin
                    n_state = S_FILL;
                end else if (w_go_sweep) begin
                    n_state = S_SWEEP;
                end
            end
            S_FILL: begin
                if (r_addr == AW'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op      = r_op;
        n_pos     = r_pos;
        n_ival    = r_ival;
        n_len     = r_len;
        n_ones    = r_ones;
        n_addr    = r_addr;
        n_last    = r_last;
        n_down    = r_down;
        n_more    = r_more;
        n_pend    = 1'b0;
        n_daddr   = r_addr;
        n_carry   = r_carry;
        n_acc     = r_acc;
        n_fillset = r_fillset;
        n_report  = r_report;
        w_done    = 1'b0;
        w_go_fill = 1'b0;
        w_go_sweep = 1'b0;
        w_bit     = 1'b0;
        w_found   = 1'b0;
        w_fidx    = '0;
        w_cnt     = '0;
        w_err     = 1'b0;
        w_masked  = '0;
        w_shift   = '0;
        w_fill    = '0;
        o_req.we    = 1'b0;
        o_req.waddr = r_daddr;
        o_req.wdata = '0;
        o_req.raddr = r_addr;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_op;
                    n_pos   = i_position;
                    n_ival  = i_insert_value;
                    n_acc   = '0;
                    n_carry = 1'b0;
                    n_more  = 1'b1;
                    n_down  = 1'b0;
                    n_addr  = w_in_wp;
                    n_last  = w_in_wp;
                    case (i_op)
                        OP_INIT: begin
                            if (i_position > LW'(MAX_BITS)) begin
                                w_err  = 1'b1;
                                w_done = 1'b1;
                            end else begin
                                w_go_fill = 1'b1;
                                n_fillset = 1'b0;
                                n_report  = 1'b1;
                                n_addr    = '0;
                                n_len     = i_position;
                                n_ones    = '0;
                            end
                        end
                        OP_SET, OP_CLEAR, OP_TEST: begin
                            if (i_position >= r_len) begin
                                w_err  = 1'b1;
                                w_done = 1'b1;
                            end else begin
                                w_go_sweep = 1'b1;
                            end
                        end
                        OP_FIND: begin
                            if (i_position >= r_len) begin
                                w_err  = 1'b1;
                                w_done = 1'b1;
                            end else begin
                                w_go_sweep = 1'b1;
                                n_last     = w_len_m1[BW+AW-1:BW];
                            end
                        end
                        OP_RANK: begin
                            if (i_position > r_len) begin
                                w_err  = 1'b1;
                                w_done = 1'b1;
                            end else if (i_position == '0) begin
                                w_done = 1'b1;
                            end else begin
                                w_go_sweep = 1'b1;
                                n_addr     = '0;
                                n_last     = w_in_pm1[BW+AW-1:BW];
                            end
                        end
                        OP_INSERT: begin
                            if (i_position > r_len || r_len >= LW'(MAX_BITS)) begin
                                w_err  = 1'b1;
                                w_done = 1'b1;
                            end else begin
                                w_go_sweep = 1'b1;
                                n_last     = r_len[BW+AW-1:BW];
                            end
                        end
                        OP_DELETE: begin
                            if (i_position >= r_len) begin
                                w_err  = 1'b1;
                                w_done = 1'b1;
                            end else begin
                                w_go_sweep = 1'b1;
                                n_down     = 1'b1;
                                n_addr     = w_len_m1[BW+AW-1:BW];
                            end
                        end
                        OP_SETALL: begin
                            w_go_fill = 1'b1;
                            n_fillset = 1'b1;
                            n_report  = 1'b1;
                            n_addr    = '0;
                            n_ones    = r_len;
                        end
                        OP_COUNT: begin
                            w_cnt  = r_ones;
                            w_done = 1'b1;
                        end
                        default: begin
                            w_err  = 1'b1;
                            w_done = 1'b1;
                        end
                    endcase
                end
            end

            S_FILL: begin
                if ({1'b0, r_addr} < r_len[LW-1:BW]) begin
                    w_fill = '1;
                end else if ({1'b0, r_addr} == r_len[LW-1:BW]) begin
                    w_fill = low_mask(r_len[BW-1:0]);
                end
                o_req.we    = 1'b1;
                o_req.waddr = r_addr;
                o_req.wdata = r_fillset ? w_fill : '0;
                n_addr      = r_addr + AW'(1);
                if (r_addr == AW'(NWORDS - 1)) begin
                    w_done = r_report;
                end
            end

            S_SWEEP: begin
                // issue the next read while the previous word comes back
                if (r_more) begin
                    n_pend  = 1'b1;
                    n_daddr = r_addr;
                    if (r_addr == r_last) begin
                        n_more = 1'b0;
                    end else begin
                        n_addr = r_down ? r_addr - AW'(1) : r_addr + AW'(1);
                    end
                end
                if (r_pend) begin
                    case (r_op)
                        OP_SET, OP_CLEAR: begin
                            o_req.we = 1'b1;
                            if (r_op == OP_SET) begin
                                o_req.wdata = i_rdata | (t_word'(1) << w_b);
                                if (!i_rdata[w_b]) n_ones = r_ones + LW'(1);
                            end else begin
                                o_req.wdata = i_rdata & ~(t_word'(1) << w_b);
                                if (i_rdata[w_b]) n_ones = r_ones - LW'(1);
                            end
                            w_done = 1'b1;
                        end
                        OP_TEST: begin
                            w_bit  = i_rdata[w_b];
                            w_done = 1'b1;
                        end
                        OP_FIND: begin
                            w_masked = (r_daddr == w_wp) ? (i_rdata & ~w_low) : i_rdata;
                            if (w_masked != '0) begin
                                w_found = 1'b1;
                                w_fidx  = {r_daddr, first_one(w_masked)};
                                w_done  = 1'b1;
                            end else if (r_daddr == r_last) begin
                                w_done = 1'b1;
                            end
                        end
                        OP_RANK: begin
                            if (r_daddr == r_last && w_b != '0) begin
                                w_masked = i_rdata & w_low;
                            end else begin
                                w_masked = i_rdata;
                            end
                            n_acc = r_acc + LW'(pop_count(w_masked));
                            w_cnt = n_acc;
                            if (r_daddr == r_last) begin
                                w_done = 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            // shift up by one from the position; top bit carries on
                            w_shift = {i_rdata[WORD_BITS-2:0], r_carry};
                            if (r_daddr == w_wp) begin
                                o_req.wdata = (i_rdata & w_low)
                                            | (t_word'(r_ival) << w_b)
                                            | ((i_rdata << 1) & ~w_low
                                               & ~(t_word'(1) << w_b));
                            end else begin
                                o_req.wdata = w_shift;
                            end
                            o_req.we = 1'b1;
                            n_carry  = i_rdata[WORD_BITS-1];
                            if (r_daddr == r_last) begin
                                n_len  = r_len + LW'(1);
                                n_ones = r_ones + LW'(r_ival);
                                w_done = 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            // walk down from the top word, pulling bit 0 of the word above
                            w_shift = {r_carry, i_rdata[WORD_BITS-1:1]};
                            if (r_daddr == w_wp) begin
                                o_req.wdata = (i_rdata & w_low) | (w_shift & ~w_low);
                            end else begin
                                o_req.wdata = w_shift;
                            end
                            o_req.we = 1'b1;
                            n_carry  = i_rdata[0];
                            if (r_daddr == r_last) begin
                                n_len  = r_len - LW'(1);
                                n_ones = r_ones - LW'(i_rdata[w_b]);
                                w_done = 1'b1;
                            end
                        end
                        default: w_done = 1'b1;
                    endcase
                end
            end

            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_addr    <= '0;
            r_len     <= '0;
            r_ones    <= '0;
            r_fillset <= 1'b0;
            r_report  <= 1'b0;
            r_more    <= 1'b0;
            r_pend    <= 1'b0;
            r_down    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_len     <= n_len;
            r_ones    <= n_ones;
            r_fillset <= n_fillset;
            r_report  <= n_report;
            r_more    <= n_more;
            r_pend    <= n_pend;
            r_down    <= n_down;
            r_valid   <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pos       <= n_pos;
        r_ival      <= n_ival;
        r_last      <= n_last;
        r_daddr     <= n_daddr;
        r_carry     <= n_carry;
        r_acc       <= n_acc;
        r_bit       <= w_bit;
        r_found     <= w_found;
        r_fidx      <= w_fidx;
        r_cnt       <= w_cnt;
        r_err       <= w_err;
        r_cur_len   <= n_len;
        r_any_zero  <= (n_ones < n_len);
        r_all_clear <= (n_ones == '0);
    end

    assign o_valid          = r_valid;
    assign o_bit_value      = r_bit;
    assign o_found          = r_found;
    assign o_found_index    = r_fidx;
    assign o_ones_count     = r_cnt;
    assign o_current_length = r_cur_len;
    assign o_any_zero       = r_any_zero;
    assign o_all_clear      = r_all_clear;
    assign o_error          = r_err;

    a_ones_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ones <= r_len) else $error("ones count exceeds length");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_BITS)) else $error("length exceeds store");

    a_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.we |-> (r_state == S_FILL || r_state == S_SWEEP))
        else $error("store write while idle");

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || $past(start)))
        else $error("result without a request");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> ({1'b0, o_found_index} < o_current_length))
        else $error("found index beyond length");

endmodule

`default_nettype wire
